[design/aec_pkg.sv]
// Shared widths, payload types and datapath commands for the arithmetic encoder core.
package aec_pkg;

	localparam int CODE_WIDTH = 32;
	localparam int FREQ_WIDTH = 16;
	localparam int IN_W       = 17;
	localparam int FOLLOW_W   = 16;
	localparam int RESULT_CAP = 33;

	localparam int RNG_W  = CODE_WIDTH + 1;
	localparam int PROD_W = RNG_W + IN_W;
	localparam int CNT_W  = $clog2(PROD_W + 1);
	localparam int N_W    = $clog2(RESULT_CAP);

	localparam logic [CODE_WIDTH-1:0] QUARTER_PT = CODE_WIDTH'(1) << (CODE_WIDTH - 2);
	localparam logic [CODE_WIDTH-1:0] HALF_PT    = CODE_WIDTH'(1) << (CODE_WIDTH - 1);

	typedef struct packed {
		logic [IN_W-1:0] cum_low;
		logic [IN_W-1:0] cum_high;
		logic [IN_W-1:0] divisor;
		logic            mode;
		logic            finish;
	} aec_sym_t;

	typedef struct packed {
		logic                code_bit;
		logic [FOLLOW_W-1:0] follow_count;
		logic                last;
	} aec_code_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL,
		OP_DIV,
		OP_CLAMP_H,
		OP_CLAMP_L,
		OP_APPLY,
		OP_RENORM,
		OP_FLUSH,
		OP_FINAL
	} aec_op_t;

	typedef struct packed {
		aec_op_t op;
	} aec_cmd_t;

	typedef struct packed {
		logic mode;
		logic fin;
		logic div_last;
		logic emit;
		logic under;
		logic cap_hit;
		logic push_ok;
		logic hold_v;
		logic order_ok;
	} aec_status_t;

endpackage

[design/aec_dp.sv]
// Datapath of the arithmetic encoder: interval, scaling, divider, renormalization, result slots.
module aec_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  aec_pkg::aec_cmd_t   cmd,
	input  aec_pkg::aec_sym_t   sym,
	input  logic                code_stall,
	output aec_pkg::aec_status_t st,
	output logic                code_valid,
	output aec_pkg::aec_code_t  code
);
	import aec_pkg::*;

	logic [CODE_WIDTH-1:0] lo_q, hi_q;
	logic [FOLLOW_W-1:0]   pend_q;
	logic [RNG_W-1:0]      range_q, sh_q, sl_q;
	logic [IN_W-1:0]       cl_q, ch_q, dv_q, rh_q, rl_q;
	logic                  mode_q, fin_q;
	logic [PROD_W-1:0]     qh_q, ql_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [N_W-1:0]        n_q;
	aec_code_t             hold_q;
	logic                  hold_v_q;
	aec_code_t             out_q;
	logic                  out_v_q;

	logic                  out_free, push, emit, under, lo_ge_hi_bad;
	logic [FOLLOW_W-1:0]   pend_inc;
	logic [IN_W:0]         rh2, rl2, rh_n, rl_n;
	logic                  qh_bit, ql_bit;
	logic [PROD_W-1:0]     sh_raw, sl_raw;
	logic [RNG_W-1:0]      sh_c, sl_lim, sl_c, hi_sum, load_range;
	logic [CODE_WIDTH-1:0] lo_sub, hi_sub;
	aec_code_t             push_data;

	assign out_free = !out_v_q || !code_stall;
	assign emit     = !hi_q[CODE_WIDTH-1] || lo_q[CODE_WIDTH-1];
	assign under    = (lo_q[CODE_WIDTH-1:CODE_WIDTH-2] == 2'b01)
		&& (hi_q[CODE_WIDTH-1:CODE_WIDTH-2] == 2'b10);
	assign pend_inc = (pend_q == '1) ? pend_q : pend_q + FOLLOW_W'(1);
	assign lo_ge_hi_bad = hi_q < lo_q;

	// restoring divide, one quotient bit per cycle for both bounds
	always_comb begin
		rh2    = {rh_q, qh_q[PROD_W-1]};
		rl2    = {rl_q, ql_q[PROD_W-1]};
		qh_bit = rh2 >= {1'b0, dv_q};
		ql_bit = rl2 >= {1'b0, dv_q};
		rh_n   = qh_bit ? rh2 - {1'b0, dv_q} : rh2;
		rl_n   = ql_bit ? rl2 - {1'b0, dv_q} : rl2;
	end

	always_comb begin
		load_range = lo_ge_hi_bad ? RNG_W'(1) : RNG_W'(hi_q) - RNG_W'(lo_q) + RNG_W'(1);
		sh_raw = mode_q ? (qh_q >> FREQ_WIDTH) : qh_q;
		sl_raw = mode_q ? (ql_q >> FREQ_WIDTH) : ql_q;
		if (sh_raw > PROD_W'(range_q))
			sh_c = range_q;
		else if (sh_raw == '0)
			sh_c = RNG_W'(1);
		else
			sh_c = sh_raw[RNG_W-1:0];
		sl_lim = sh_q - RNG_W'(1);
		sl_c   = (sl_raw > PROD_W'(sl_lim)) ? sl_lim : sl_raw[RNG_W-1:0];
		hi_sum = RNG_W'(lo_q) + sh_q - RNG_W'(1);
		if (lo_q[CODE_WIDTH-1]) begin
			lo_sub = lo_q - HALF_PT;
			hi_sub = hi_q - HALF_PT;
		end else if (!emit) begin
			lo_sub = lo_q - QUARTER_PT;
			hi_sub = hi_q - QUARTER_PT;
		end else begin
			lo_sub = lo_q;
			hi_sub = hi_q;
		end
	end

	always_comb begin
		push      = hold_v_q && ((cmd.op == OP_RENORM && emit) || cmd.op == OP_FLUSH
			|| cmd.op == OP_FINAL);
		push_data = hold_q;
		push_data.last = (cmd.op == OP_FINAL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q     <= '0;
			hi_q     <= '1;
			pend_q   <= '0;
			n_q      <= '0;
			cnt_q    <= '0;
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (push) begin
				out_q   <= push_data;
				out_v_q <= 1'b1;
			end else if (out_free) begin
				out_v_q <= 1'b0;
			end
			unique case (cmd.op)
				OP_LOAD: begin
					cl_q    <= sym.cum_low;
					ch_q    <= sym.cum_high;
					dv_q    <= (sym.divisor == '0) ? IN_W'(1) : sym.divisor;
					mode_q  <= sym.mode;
					fin_q   <= sym.finish;
					range_q <= load_range;
					n_q     <= '0;
				end
				OP_MUL: begin
					qh_q  <= PROD_W'(range_q) * PROD_W'(ch_q);
					ql_q  <= PROD_W'(range_q) * PROD_W'(cl_q);
					rh_q  <= '0;
					rl_q  <= '0;
					cnt_q <= CNT_W'(PROD_W);
				end
				OP_DIV: begin
					qh_q  <= {qh_q[PROD_W-2:0], qh_bit};
					ql_q  <= {ql_q[PROD_W-2:0], ql_bit};
					rh_q  <= rh_n[IN_W-1:0];
					rl_q  <= rl_n[IN_W-1:0];
					cnt_q <= cnt_q - CNT_W'(1);
				end
				OP_CLAMP_H: sh_q <= sh_c;
				OP_CLAMP_L: sl_q <= sl_c;
				OP_APPLY: begin
					hi_q <= hi_sum[CODE_WIDTH-1:0];
					lo_q <= lo_q + sl_q[CODE_WIDTH-1:0];
				end
				OP_RENORM: begin
					if (emit) begin
						hold_q.code_bit     <= hi_q[CODE_WIDTH-1];
						hold_q.follow_count <= pend_q;
						hold_q.last         <= 1'b0;
						hold_v_q            <= 1'b1;
						pend_q              <= '0;
						n_q                 <= n_q + N_W'(1);
					end else begin
						pend_q <= pend_inc;
					end
					lo_q <= {lo_sub[CODE_WIDTH-2:0], 1'b0};
					hi_q <= {hi_sub[CODE_WIDTH-2:0], 1'b1};
				end
				OP_FLUSH: begin
					hold_q.code_bit     <= |lo_q[CODE_WIDTH-1:CODE_WIDTH-2];
					hold_q.follow_count <= pend_inc;
					hold_q.last         <= 1'b0;
					hold_v_q            <= 1'b1;
					lo_q                <= '0;
					hi_q                <= '1;
					pend_q              <= '0;
				end
				OP_FINAL: hold_v_q <= 1'b0;
				default: ;
			endcase
		end
	end

	always_comb begin
		st.mode     = mode_q;
		st.fin      = fin_q;
		st.div_last = (cnt_q == CNT_W'(1));
		st.emit     = emit;
		st.under    = under;
		st.cap_hit  = (n_q == N_W'(RESULT_CAP - 1));
		st.push_ok  = !hold_v_q || out_free;
		st.hold_v   = hold_v_q;
		st.order_ok = !lo_ge_hi_bad;
	end

	assign code_valid = out_v_q;
	assign code       = out_q;

endmodule

[design/aec_ctrl.sv]
// Sequencer of the arithmetic encoder: steps the datapath through one symbol.
module aec_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sym_valid,
	input  aec_pkg::aec_status_t st,
	output logic                 sym_stall,
	output aec_pkg::aec_cmd_t    cmd
);
	import aec_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_DIV, S_CLAMP_H, S_CLAMP_L, S_APPLY, S_RENORM, S_FLUSH, S_FINAL
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   go_on;

	// keep renormalizing while a bit is due (below the cap) or an underflow applies
	assign go_on = st.emit ? !st.cap_hit : st.under;

	always_comb begin
		cmd.op = OP_NONE;
		unique case (state_q)
			S_IDLE:    if (sym_valid) cmd.op = OP_LOAD;
			S_MUL:     cmd.op = OP_MUL;
			S_DIV:     cmd.op = OP_DIV;
			S_CLAMP_H: cmd.op = OP_CLAMP_H;
			S_CLAMP_L: cmd.op = OP_CLAMP_L;
			S_APPLY:   cmd.op = OP_APPLY;
			S_RENORM:  if (go_on && (!st.emit || st.push_ok)) cmd.op = OP_RENORM;
			S_FLUSH:   if (st.push_ok) cmd.op = OP_FLUSH;
			S_FINAL:   if (st.push_ok) cmd.op = OP_FINAL;
			default:   cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (sym_valid) begin
					state_q <= S_MUL;
					busy_q  <= 1'b1;
				end
				S_MUL:     state_q <= st.mode ? S_CLAMP_H : S_DIV;
				S_DIV:     if (st.div_last) state_q <= S_CLAMP_H;
				S_CLAMP_H: state_q <= S_CLAMP_L;
				S_CLAMP_L: state_q <= S_APPLY;
				S_APPLY:   state_q <= S_RENORM;
				S_RENORM:  if (!go_on) state_q <= st.fin ? S_FLUSH : S_FINAL;
				S_FLUSH:   if (st.push_ok) state_q <= S_FINAL;
				S_FINAL: if (st.push_ok) begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign sym_stall = busy_q;

endmodule

[design/arithmetic_encoder_core.sv]
// Top level of the integer binary arithmetic encoder core.
//
//  channel | dir | handshake              | payload
//  sym     | in  | sym_valid / sym_stall  | aec_sym_t  (cum_low, cum_high, divisor, mode, finish)
//  code    | out | code_valid / code_stall| aec_code_t (code_bit, follow_count, last)
//
// One symbol at a time: load, multiply, then in divide mode a bit-serial divider
// (both bounds at once), high clamp, low clamp, apply, the renormalization steps,
// a flush on finish and a closing step.
// Reset puts low at zero, high at all ones and the pending count at zero.
// A stalled code output holds the sequencer only when a further transfer is due.
module arithmetic_encoder_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sym_valid,
	output logic               sym_stall,
	input  aec_pkg::aec_sym_t  sym,
	output logic               code_valid,
	input  logic               code_stall,
	output aec_pkg::aec_code_t code
);
	import aec_pkg::*;

	aec_cmd_t    cmd;
	aec_status_t st;

	aec_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym_valid (sym_valid),
		.st        (st),
		.sym_stall (sym_stall),
		.cmd       (cmd)
	);

	aec_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sym        (sym),
		.code_stall (code_stall),
		.st         (st),
		.code_valid (code_valid),
		.code       (code)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(sym_valid && !sym_stall) |=> sym_stall)
		else $error("no stall after symbol transfer");

	a_idle_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!sym_stall |-> !st.hold_v)
		else $error("result held while idle");

	a_idle_order: assert property (@(posedge clk) disable iff (!arst_n)
		!sym_stall |-> st.order_ok)
		else $error("interval low above high while idle");

endmodule
